@@ design/psv_pkg.sv @@
// shared types, codes and constants for the pitched sample playback voice
`timescale 1ns / 1ps

package psv_pkg;

    typedef enum logic [1:0] {
        KIND_NOTE_ON  = 2'd0,
        KIND_NOTE_OFF = 2'd1,
        KIND_TICK     = 2'd2,
        KIND_WRITE    = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        CFG_ROOT_NOTE      = 3'd0,
        CFG_SAMPLE_LENGTH  = 3'd1,
        CFG_STEREO_SOURCE  = 3'd2,
        CFG_TIGHTNESS      = 3'd3,
        CFG_HARMONIC_BLEND = 3'd4
    } cfg_index_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_CHECK,
        OP_LERP_L,
        OP_LERP_R,
        OP_VEL_L,
        OP_VEL_R,
        OP_DIV_L,
        OP_FIX_L,
        OP_DIV_R,
        OP_FIX_R,
        OP_DIV_START,
        OP_SUM,
        OP_LOAD
    } dp_op_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_LERP_L,
        ST_LERP_R,
        ST_VEL_L,
        ST_VEL_R,
        ST_DIV_L,
        ST_FIX_L,
        ST_DIV_R,
        ST_FIX_R,
        ST_BLEND,
        ST_DIVWAIT,
        ST_SUM,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic   accept;
        dp_op_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic silent;
        logic blend;
        logic div_done;
    } dp_stat_t;

    typedef struct packed {
        kind_t              kind;
        logic [6:0]         note;
        logic [6:0]         velocity;
        logic [16:0]        timing_offset;
        logic [18:0]        sidechain_pitch;
        logic [15:0]        sample_address;
        logic signed [15:0] sample_left;
        logic signed [15:0] sample_right;
    } in_item_t;

    typedef struct packed {
        logic signed [15:0] out_left;
        logic signed [15:0] out_right;
        logic               voice_active;
    } out_item_t;

    localparam logic [16:0] UNIT_Q16     = 17'd65536;
    localparam logic [18:0] SC_MIN       = 19'd320;
    localparam logic [8:0]  NOTE_BIAS    = 9'd132;
    localparam logic [7:0]  ROOT_BIAS    = 8'd63;
    localparam logic [9:0]  DIV12_MUL    = 10'd683;
    localparam int          DIV12_SH     = 13;
    localparam logic [14:0] DIV127_MUL   = 15'd16513;
    localparam int          DIV127_SH    = 21;
    localparam logic [8:0]  ROOT_HZ_MUL  = 9'd440;
    localparam logic [5:0]  OCT_BIAS     = 6'd11;

    function automatic logic [16:0] semitone(input logic [3:0] k);
        logic [16:0] v;
        case (k)
            4'd0:    v = 17'd65536;
            4'd1:    v = 17'd69433;
            4'd2:    v = 17'd73562;
            4'd3:    v = 17'd77936;
            4'd4:    v = 17'd82570;
            4'd5:    v = 17'd87480;
            4'd6:    v = 17'd92682;
            4'd7:    v = 17'd98193;
            4'd8:    v = 17'd104032;
            4'd9:    v = 17'd110218;
            4'd10:   v = 17'd116772;
            4'd11:   v = 17'd123715;
            default: v = 17'd65536;
        endcase
        return v;
    endfunction

    // octave shift, right shifts rounded half up
    function automatic logic [39:0] pitch_shift(input logic [16:0] v,
                                                input logic signed [5:0] sh);
        logic [39:0] w;
        logic [5:0]  n;
        w = 40'(v);
        n = 6'(-sh);
        if (sh >= 0) begin
            return w << sh;
        end
        return (w + (40'd1 << (n - 6'd1))) >> n;
    endfunction

endpackage

@@ design/psv_ctrl.sv @@
// sequencing state machine for the voice: handshakes and datapath steps
`timescale 1ns / 1ps

module psv_ctrl
    import psv_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  kind_t    s_kind,
    output logic     m_valid,
    input  logic     m_ready,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;
    logic   out_free;

    assign out_free = !m_valid_reg || m_ready;
    assign m_valid  = m_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid && s_kind == KIND_TICK) begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:   state_next = stat.silent ? ST_DONE : ST_LERP_L;
            ST_LERP_L:  state_next = ST_LERP_R;
            ST_LERP_R:  state_next = ST_VEL_L;
            ST_VEL_L:   state_next = ST_VEL_R;
            ST_VEL_R:   state_next = ST_DIV_L;
            ST_DIV_L:   state_next = ST_FIX_L;
            ST_FIX_L:   state_next = ST_DIV_R;
            ST_DIV_R:   state_next = ST_FIX_R;
            ST_FIX_R:   state_next = stat.blend ? ST_BLEND : ST_SUM;
            ST_BLEND:   state_next = ST_DIVWAIT;
            ST_DIVWAIT: begin
                if (stat.div_done) begin
                    state_next = ST_SUM;
                end
            end
            ST_SUM:     state_next = ST_DONE;
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default:    state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_ready    = (state_reg == ST_IDLE);
        cmd.accept = s_valid && (state_reg == ST_IDLE);
        cmd.op     = OP_NONE;
        unique case (state_reg)
            ST_IDLE:    cmd.op = OP_NONE;
            ST_CHECK:   cmd.op = OP_CHECK;
            ST_LERP_L:  cmd.op = OP_LERP_L;
            ST_LERP_R:  cmd.op = OP_LERP_R;
            ST_VEL_L:   cmd.op = OP_VEL_L;
            ST_VEL_R:   cmd.op = OP_VEL_R;
            ST_DIV_L:   cmd.op = OP_DIV_L;
            ST_FIX_L:   cmd.op = OP_FIX_L;
            ST_DIV_R:   cmd.op = OP_DIV_R;
            ST_FIX_R:   cmd.op = OP_FIX_R;
            ST_BLEND:   cmd.op = OP_DIV_START;
            ST_DIVWAIT: cmd.op = OP_NONE;
            ST_SUM:     cmd.op = OP_SUM;
            ST_DONE:    cmd.op = out_free ? OP_LOAD : OP_NONE;
            default:    cmd.op = OP_NONE;
        endcase
        if (cmd.op == OP_LOAD) begin
            m_valid_next = 1'b1;
        end else if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

`ifndef SYNTH
    a_tick_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_kind == KIND_TICK |=> state_reg == ST_CHECK)
        else $error("accepted tick did not start processing");

    a_div_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_DIVWAIT && !stat.div_done |=> state_reg == ST_DIVWAIT)
        else $error("left divide wait early");

    a_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.op == OP_LOAD |-> (!m_valid_reg || m_ready))
        else $error("result overwrote a pending transfer");

    a_valid_from_done: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == ST_DONE))
        else $error("result raised outside done state");
`endif

endmodule

@@ design/psv_div.sv @@
// restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps

module psv_div #(
    parameter int NW = 52,
    parameter int DW = 34
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          start,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    output logic          done,
    output logic [NW-1:0] quo
);

    localparam int CW = $clog2(NW + 1);

    logic          busy_reg;
    logic          done_reg;
    logic [CW-1:0] cnt_reg;
    logic [DW-1:0] rem_reg;
    logic [DW-1:0] den_reg;
    logic [NW-1:0] quo_reg;
    logic [DW:0]   rem_sh;
    logic [DW:0]   diff;
    logic          ge;

    assign rem_sh = {rem_reg, quo_reg[NW-1]};
    assign diff   = rem_sh - {1'b0, den_reg};
    assign ge     = rem_sh >= {1'b0, den_reg};
    assign done   = done_reg;
    assign quo    = quo_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(NW);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - CW'(1);
                if (cnt_reg == CW'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= '0;
            quo_reg <= num;
            den_reg <= den;
        end else if (busy_reg) begin
            rem_reg <= ge ? diff[DW-1:0] : rem_sh[DW-1:0];
            quo_reg <= {quo_reg[NW-2:0], ge};
        end
    end

endmodule

@@ design/psv_datapath.sv @@
// voice datapath: sample memory, playhead, rate and output arithmetic
`timescale 1ns / 1ps

module psv_datapath
    import psv_pkg::*;
#(
    parameter int SAMPLE_DEPTH = 65536,
    parameter int FRAC_BITS    = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  dp_cmd_t     cmd,
    input  in_item_t    s_item,
    input  logic        cfg_valid,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data,
    output dp_stat_t    stat,
    output out_item_t   m_item
);

    localparam int AW   = $clog2(SAMPLE_DEPTH);
    localparam int LW   = AW + 1;
    localparam int PW   = LW + FRAC_BITS;
    localparam int RW   = FRAC_BITS + 12;
    localparam int ADW  = (AW > 16 ? AW : 16) + 1;
    localparam int CLW  = (LW > 17 ? LW : 17);
    localparam int NW   = 36 + FRAC_BITS;
    localparam int DW   = 34;
    localparam int PPW  = FRAC_BITS + 18;
    localparam int MW   = FRAC_BITS + 17;
    localparam int QW   = FRAC_BITS + 24;
    localparam int XW   = QW - FRAC_BITS;
    localparam int RTW  = FRAC_BITS + 3;
    localparam int WPW  = FRAC_BITS + 2;
    localparam int SW   = NW + 1;

    localparam logic [RTW-1:0] LO_RATE =
        RTW'(((64'd1 << FRAC_BITS) + 64'd5) / 64'd10);
    localparam logic [RTW-1:0] HI_RATE  = RTW'(64'd4 << FRAC_BITS);
    localparam logic [QW-1:0]  HALF_DEN = QW'(64'd127 << (FRAC_BITS - 1));

    // configuration
    logic [6:0]    root_reg;
    logic [LW-1:0] len_reg;
    logic          stereo_reg;
    logic [16:0]   tight_reg;
    logic [16:0]   blend_reg;

    // voice state
    logic [PW-1:0] playhead_reg;
    logic          playing_reg;
    logic [6:0]    note_reg;
    logic [6:0]    vel_reg;

    // per-tick working registers
    logic [16:0]            ofs_reg;
    logic [18:0]            sc_reg;
    logic                   blend_go_reg;
    logic [4:0]             q1_reg, q2_reg;
    logic [3:0]             k1_reg, k2_reg;
    logic [31:0]            rd_a_reg, rd_b_reg;
    logic [RW-1:0]          ratio_reg, rb_reg;
    logic [20:0]            rh16_reg;
    logic [29:0]            rh_reg;
    logic signed [PPW-1:0]  pl_reg, pr_reg;
    logic [QW-1:0]          ql_reg, qr_reg;
    logic                   negl_reg, negr_reg;
    logic [35:0]            scb_reg;
    logic [WPW-1:0]         warp_reg;
    logic [XW-1:0]          x_reg;
    logic [16:0]            q0_reg;
    logic signed [15:0]     res_l_reg, res_r_reg;
    logic                   act_reg;
    out_item_t              m_item_reg;

    logic [31:0] mem [SAMPLE_DEPTH];

    // combinational helpers
    logic [CLW-1:0]        len_wide;
    logic [16:0]           cfg17;
    logic [ADW-1:0]        addr_ext;
    logic                  addr_ok;
    logic [LW-1:0]         idx, nx, idx_inc;
    logic                  silent;
    logic [8:0]            u1;
    logic [7:0]            u2;
    logic [18:0]           u1m;
    logic [17:0]           u2m;
    logic [4:0]            q1, q2;
    logic signed [5:0]     sh1, sh2;
    logic [FRAC_BITS-1:0]  frac;
    logic signed [FRAC_BITS:0] frac_s;
    logic signed [15:0]    a_l, n_l, a_r, n_r, a_sel, n_sel;
    logic signed [16:0]    dlt;
    logic signed [PPW-1:0] lerp;
    logic signed [PPW-1:0] p_sel;
    logic [MW-1:0]         mag;
    logic [QW-1:0]         qv;
    logic [RW+16:0]        rb_full;
    logic [34:0]           warp_full;
    logic [XW-1:0]         x_sel;
    logic [XW+14:0]        xm;
    logic [XW-1:0]         remd;
    logic [16:0]           qf;
    logic                  neg_sel;
    logic signed [15:0]    res_sat;
    logic [SW-1:0]         rsum;
    logic [RTW-1:0]        rate;
    logic [NW-1:0]         div_quo;
    logic                  div_done;

    function automatic logic [16:0] sat_unit(input logic [16:0] v);
        return (v > UNIT_Q16) ? UNIT_Q16 : v;
    endfunction

    function automatic logic signed [15:0] sat_out(input logic neg, input logic [16:0] q);
        logic signed [15:0] r;
        if (neg) begin
            r = (q > 17'd32768) ? -16'sd32768 : 16'(-q);
        end else begin
            r = (q > 17'd32767) ? 16'sd32767 : 16'(q);
        end
        return r;
    endfunction

    assign cfg17    = cfg_data[16:0];
    assign len_wide = CLW'(cfg17);
    assign addr_ext = ADW'(s_item.sample_address);
    assign addr_ok  = addr_ext < ADW'(SAMPLE_DEPTH);

    assign idx     = playhead_reg[PW-1:FRAC_BITS];
    assign idx_inc = idx + LW'(1);
    assign nx      = (idx_inc < len_reg) ? idx_inc : len_reg - LW'(1);
    assign silent  = !playing_reg || (len_reg == '0) || (idx >= len_reg);

    assign u1  = {2'b0, note_reg} + NOTE_BIAS - {2'b0, root_reg};
    assign u2  = {1'b0, root_reg} + ROOT_BIAS;
    assign u1m = u1 * DIV12_MUL;
    assign u2m = u2 * DIV12_MUL;
    assign q1  = 5'(u1m >> DIV12_SH);
    assign q2  = 5'(u2m >> DIV12_SH);
    assign sh1 = $signed(6'({1'b0, q1_reg}) + 6'(FRAC_BITS - 27));
    assign sh2 = $signed(6'({1'b0, q2_reg}) - OCT_BIAS);

    assign frac   = playhead_reg[FRAC_BITS-1:0];
    assign frac_s = $signed({1'b0, frac});
    assign a_l    = $signed(rd_a_reg[15:0]);
    assign n_l    = $signed(rd_b_reg[15:0]);
    assign a_r    = stereo_reg ? $signed(rd_a_reg[31:16]) : a_l;
    assign n_r    = stereo_reg ? $signed(rd_b_reg[31:16]) : n_l;
    assign a_sel  = (cmd.op == OP_LERP_R) ? a_r : a_l;
    assign n_sel  = (cmd.op == OP_LERP_R) ? n_r : n_l;
    assign dlt    = 17'(n_sel) - 17'(a_sel);
    assign lerp   = (PPW'(a_sel) <<< FRAC_BITS) + dlt * frac_s;

    assign p_sel  = (cmd.op == OP_VEL_R) ? pr_reg : pl_reg;
    assign mag    = p_sel[PPW-1] ? MW'(-p_sel) : MW'(p_sel);
    assign qv     = QW'(mag * vel_reg) + HALF_DEN;

    assign rb_full   = ratio_reg * (UNIT_Q16 - blend_reg);
    assign warp_full = {34'(ofs_reg) * 34'(tight_reg), 1'b0};

    assign x_sel   = (cmd.op == OP_DIV_R) ? qr_reg[QW-1:FRAC_BITS] : ql_reg[QW-1:FRAC_BITS];
    assign xm      = x_sel * DIV127_MUL;
    assign remd    = x_reg - XW'(q0_reg * 7'd127);
    assign qf      = (remd >= XW'(127)) ? q0_reg + 17'd1 : q0_reg;
    assign neg_sel = (cmd.op == OP_FIX_R) ? negr_reg : negl_reg;
    assign res_sat = sat_out(neg_sel, qf);

    assign rsum = (blend_go_reg ? SW'(rb_reg) + SW'(div_quo) : SW'(ratio_reg))
                  + SW'(warp_reg);
    assign rate = (rsum < SW'(LO_RATE)) ? LO_RATE :
                  (rsum > SW'(HI_RATE)) ? HI_RATE : RTW'(rsum);

    assign stat.silent   = silent;
    assign stat.blend    = blend_go_reg;
    assign stat.div_done = div_done;
    assign m_item        = m_item_reg;

    psv_div #(
        .NW (NW),
        .DW (DW)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.op == OP_DIV_START),
        .num     (NW'(scb_reg) << FRAC_BITS),
        .den     ({rh_reg, 4'b0}),
        .done    (div_done),
        .quo     (div_quo)
    );

    // configuration and voice state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            root_reg     <= 7'd60;
            len_reg      <= '0;
            stereo_reg   <= 1'b0;
            tight_reg    <= '0;
            blend_reg    <= '0;
            playhead_reg <= '0;
            playing_reg  <= 1'b0;
            note_reg     <= '0;
            vel_reg      <= '0;
        end else begin
            if (cfg_valid) begin
                unique case (cfg_index)
                    CFG_ROOT_NOTE:      root_reg   <= cfg_data[6:0];
                    CFG_SAMPLE_LENGTH:  len_reg    <= (len_wide > CLW'(SAMPLE_DEPTH)) ?
                                                      LW'(SAMPLE_DEPTH) : LW'(len_wide);
                    CFG_STEREO_SOURCE:  stereo_reg <= cfg_data[0];
                    CFG_TIGHTNESS:      tight_reg  <= sat_unit(cfg17);
                    CFG_HARMONIC_BLEND: blend_reg  <= sat_unit(cfg17);
                    default: ;
                endcase
            end
            if (cmd.accept) begin
                unique case (s_item.kind)
                    KIND_NOTE_ON: begin
                        if (s_item.velocity == 7'd0) begin
                            playing_reg <= 1'b0;
                        end else begin
                            note_reg     <= s_item.note;
                            vel_reg      <= s_item.velocity;
                            playhead_reg <= '0;
                            playing_reg  <= 1'b1;
                        end
                    end
                    KIND_NOTE_OFF: playing_reg <= 1'b0;
                    KIND_WRITE: begin
                        playing_reg  <= 1'b0;
                        playhead_reg <= '0;
                    end
                    KIND_TICK: ;
                    default: ;
                endcase
            end
            if (cmd.op == OP_CHECK && playing_reg && len_reg != '0 && idx >= len_reg) begin
                playing_reg <= 1'b0;
            end
            if (cmd.op == OP_SUM) begin
                playhead_reg <= playhead_reg + PW'(rate);
            end
        end
    end

    // per-tick arithmetic
    always_ff @(posedge aclk) begin
        if (cmd.accept && s_item.kind == KIND_TICK) begin
            ofs_reg      <= sat_unit(s_item.timing_offset);
            sc_reg       <= s_item.sidechain_pitch;
            blend_go_reg <= (blend_reg != '0) && (s_item.sidechain_pitch > SC_MIN);
        end
        case (cmd.op)
            OP_CHECK: begin
                q1_reg    <= q1;
                k1_reg    <= 4'(u1 - 9'(q1 * 4'd12));
                q2_reg    <= q2;
                k2_reg    <= 4'(u2 - 8'(q2 * 4'd12));
                res_l_reg <= '0;
                res_r_reg <= '0;
                act_reg   <= playing_reg && (len_reg == '0);
            end
            OP_LERP_L: begin
                pl_reg    <= lerp;
                ratio_reg <= RW'(pitch_shift(semitone(k1_reg), sh1));
                rh16_reg  <= 21'(pitch_shift(semitone(k2_reg), sh2));
            end
            OP_LERP_R: begin
                pr_reg <= lerp;
                rh_reg <= 30'(rh16_reg * ROOT_HZ_MUL);
            end
            OP_VEL_L: begin
                ql_reg   <= qv;
                negl_reg <= p_sel[PPW-1];
                rb_reg   <= RW'(rb_full >> 16);
            end
            OP_VEL_R: begin
                qr_reg   <= qv;
                negr_reg <= p_sel[PPW-1];
                scb_reg  <= sc_reg * blend_reg;
                warp_reg <= WPW'(warp_full >> (32 - FRAC_BITS));
            end
            OP_DIV_L, OP_DIV_R: begin
                x_reg  <= x_sel;
                q0_reg <= 17'(xm >> DIV127_SH);
            end
            OP_FIX_L: res_l_reg <= res_sat;
            OP_FIX_R: res_r_reg <= res_sat;
            OP_SUM:   act_reg   <= 1'b1;
            OP_LOAD: begin
                m_item_reg.out_left     <= res_l_reg;
                m_item_reg.out_right    <= res_r_reg;
                m_item_reg.voice_active <= act_reg;
            end
            default: ;
        endcase
    end

    // stereo frame memory, right in the upper half
    always_ff @(posedge aclk) begin
        if (cmd.accept && s_item.kind == KIND_WRITE && addr_ok) begin
            mem[addr_ext[AW-1:0]] <= {s_item.sample_right, s_item.sample_left};
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.op == OP_CHECK) begin
            rd_a_reg <= mem[idx[AW-1:0]];
            rd_b_reg <= mem[nx[AW-1:0]];
        end
    end

endmodule

@@ design/pitched_sample_playback_voice_unit.sv @@
// top level of the one-voice pitched sample player
//
//   channel   direction  handshake           payload
//   s_        in         s_valid / s_ready    in_item_t
//   m_        out        m_valid / m_ready    out_item_t
//   cfg_      in         cfg_valid / cfg_ready cfg_index, cfg_data
//
// note on, note off and sample writes leave the unit ready for the next item
// a tick skips the datapath steps when silent; when pitch blending is on it
// also waits for the one-bit-per-cycle rate divider
// a finished result waits in the output register; new items are taken meanwhile
// a tick does not finish while an earlier result is still waiting
// reset returns play state and configuration to defaults; sample memory holds no reset value
`timescale 1ns / 1ps

module pitched_sample_playback_voice_unit
    import psv_pkg::*;
#(
    parameter int SAMPLE_DEPTH = 65536,
    parameter int FRAC_BITS    = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  in_item_t    s_item,
    output logic        m_valid,
    input  logic        m_ready,
    output out_item_t   m_item,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    assign cfg_ready = 1'b1;

    psv_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_kind  (s_item.kind),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    psv_datapath #(
        .SAMPLE_DEPTH (SAMPLE_DEPTH),
        .FRAC_BITS    (FRAC_BITS)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .s_item    (s_item),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .stat      (stat),
        .m_item    (m_item)
    );

endmodule

@@ verif/psv_checker.sv @@
// transfer monitor, playback predictor and result comparison for the voice unit
`timescale 1ns / 1ps

module psv_checker
    import psv_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  in_item_t    s_item,
    input  logic        m_valid,
    input  logic        m_ready,
    input  out_item_t   m_item,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data,
    output int          fail_count,
    output int          pending_ticks,
    output int          ticks_checked
);

    int unsigned semis [12] = '{65536, 69433, 73562, 77936, 82570, 87480,
                                92682, 98193, 104032, 110218, 116772, 123715};

    logic signed [15:0] mem_l [int];
    logic signed [15:0] mem_r [int];
    longint unsigned    head;
    bit                 playing;
    int unsigned        note_q, vel_q;
    int unsigned        root_q, len_q, stereo_q, tight_q, blend_q;
    out_item_t          tick_q [$];

    function automatic longint unsigned unit_sat(longint unsigned v);
        return (v > 65536) ? 64'd65536 : v;
    endfunction

    // 2^(d/12) in q16
    function automatic longint unsigned pitch_gain(int d);
        int u, k, oct;
        longint unsigned v;
        u = d + 132;
        k = u % 12;
        oct = u / 12 - 11;
        v = semis[k];
        if (oct >= 0) begin
            return v << oct;
        end
        return (v + (64'd1 << (-oct - 1))) >> (-oct);
    endfunction

    function automatic longint unsigned step_size(longint unsigned ofs, longint unsigned sc);
        longint unsigned b, t, o, r, hz, term;
        b = unit_sat(blend_q);
        t = unit_sat(tight_q);
        o = unit_sat(ofs);
        r = pitch_gain(int'(note_q) - int'(root_q));
        if (b > 0 && sc > 320) begin
            hz = pitch_gain(int'(root_q) - 69) * 440;
            term = ((sc * b) << 16) / (hz * 16);
            r = ((r * (65536 - b)) >> 16) + term;
        end
        r += (2 * o * t) >> 16;
        if (r < 6554) r = 6554;
        if (r > 262144) r = 262144;
        return r;
    endfunction

    function automatic logic [15:0] vel_scale(longint p);
        longint q, m, r, den;
        q = p * longint'(vel_q);
        den = longint'(127) << 16;
        m = (q < 0) ? -q : q;
        r = (m + den / 2) / den;
        if (q < 0) r = -r;
        if (r > 32767) r = 32767;
        if (r < -32768) r = -32768;
        return r[15:0];
    endfunction

    function automatic longint frame_l(int a);
        return mem_l.exists(a) ? longint'(mem_l[a]) : 0;
    endfunction

    function automatic longint frame_r(int a);
        return mem_r.exists(a) ? longint'(mem_r[a]) : 0;
    endfunction

    function automatic out_item_t play_tick(in_item_t it);
        out_item_t res;
        longint unsigned len, idx, nx;
        longint f, g, al, nl, ar, nr;
        res = '0;
        len = (len_q > 65536) ? 64'd65536 : len_q;
        if (playing && len > 0) begin
            idx = head >> 16;
            if (idx >= len) begin
                playing = 0;
            end else begin
                nx = (idx + 1 < len) ? idx + 1 : len - 1;
                f = longint'(head & 64'hFFFF);
                g = 65536 - f;
                al = frame_l(int'(idx));
                nl = frame_l(int'(nx));
                ar = stereo_q ? frame_r(int'(idx)) : al;
                nr = stereo_q ? frame_r(int'(nx)) : nl;
                res.out_left = vel_scale(al * g + nl * f);
                res.out_right = vel_scale(ar * g + nr * f);
                head += step_size(it.timing_offset, it.sidechain_pitch);
            end
        end
        res.voice_active = playing;
        return res;
    endfunction

    always @(posedge aclk) begin
        out_item_t want;
        if (!aresetn) begin
            head = 0;
            playing = 0;
            note_q = 0;
            vel_q = 0;
            root_q = 60;
            len_q = 0;
            stereo_q = 0;
            tight_q = 0;
            blend_q = 0;
            tick_q.delete();
            fail_count = 0;
            ticks_checked = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (tick_q.size() == 0) begin
                    $error("unexpected result transfer");
                    fail_count++;
                end else begin
                    want = tick_q.pop_front();
                    ticks_checked++;
                    if (m_item.out_left !== want.out_left) begin
                        $error("out_left expected %0d got %0d", want.out_left, m_item.out_left);
                        fail_count++;
                    end
                    if (m_item.out_right !== want.out_right) begin
                        $error("out_right expected %0d got %0d", want.out_right,
                               m_item.out_right);
                        fail_count++;
                    end
                    if (m_item.voice_active !== want.voice_active) begin
                        $error("voice_active expected %0d got %0d", want.voice_active,
                               m_item.voice_active);
                        fail_count++;
                    end
                end
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_ROOT_NOTE:      root_q = cfg_data[6:0];
                    CFG_SAMPLE_LENGTH:  len_q = cfg_data[16:0];
                    CFG_STEREO_SOURCE:  stereo_q = cfg_data[0];
                    CFG_TIGHTNESS:      tight_q = cfg_data[16:0];
                    CFG_HARMONIC_BLEND: blend_q = cfg_data[16:0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                case (s_item.kind)
                    KIND_NOTE_ON: begin
                        if (s_item.velocity == 0) begin
                            playing = 0;
                        end else begin
                            note_q = s_item.note;
                            vel_q = s_item.velocity;
                            head = 0;
                            playing = 1;
                        end
                    end
                    KIND_NOTE_OFF: playing = 0;
                    KIND_WRITE: begin
                        mem_l[int'(s_item.sample_address)] = s_item.sample_left;
                        mem_r[int'(s_item.sample_address)] = s_item.sample_right;
                        playing = 0;
                        head = 0;
                    end
                    default: tick_q.push_back(play_tick(s_item));
                endcase
            end
        end
        pending_ticks = tick_q.size();
    end

endmodule

@@ verif/testbench.sv @@
// stimulus, handshake pacing and verdict for the pitched sample playback voice
`timescale 1ns / 1ps

module testbench;
    import psv_pkg::*;

    localparam int FILLED = 300;
    localparam int LIMIT  = 800000;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    in_item_t    s_item;
    logic        m_valid;
    logic        m_ready;
    out_item_t   m_item;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [31:0] cfg_data;
    int          fail_count, pending_ticks, ticks_checked;

    bit          calm;
    bit          hold_req;
    int          cycles = 0;
    int          since_rewind;
    int          items_sent;
    int          phases_run;
    int unsigned cur_root;

    pitched_sample_playback_voice_unit dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_item(s_item),
        .m_valid(m_valid), .m_ready(m_ready), .m_item(m_item),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    psv_checker u_checker (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_item(s_item),
        .m_valid(m_valid), .m_ready(m_ready), .m_item(m_item),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .fail_count(fail_count), .pending_ticks(pending_ticks),
        .ticks_checked(ticks_checked)
    );

    initial begin
        aclk = 0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // receiver pacing, with a single long hold-off
    initial begin
        int held;
        bit hold_taken;
        held = 0;
        hold_taken = 0;
        m_ready = 0;
        forever begin
            @(posedge aclk);
            if (hold_req && !hold_taken) begin
                m_ready <= 0;
                held++;
                if (held >= 500) begin
                    hold_taken = 1;
                    held = 0;
                end
            end else begin
                m_ready <= calm || ($urandom_range(99) >= 17);
            end
        end
    end

    task automatic send(in_item_t it);
        if (!calm && $urandom_range(99) < 17) begin
            s_valid <= 0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        if (it.kind == KIND_TICK && since_rewind * 4 + 2 > FILLED) begin
            // keep the playhead inside the frames written so far
            it.kind = KIND_NOTE_ON;
            it.velocity[0] = 1'b1;
        end
        if (it.kind == KIND_TICK) since_rewind++;
        if (it.kind == KIND_WRITE || (it.kind == KIND_NOTE_ON && it.velocity != 0))
            since_rewind = 0;
        s_valid <= 1;
        s_item <= it;
        do @(posedge aclk); while (!s_ready);
        items_sent++;
    endtask

    task automatic drain();
        s_valid <= 0;
        do @(posedge aclk); while (pending_ticks != 0);
        repeat (80) @(posedge aclk);
    endtask

    task automatic set_regs(int unsigned root, int unsigned len, int unsigned st,
                            int unsigned tight, int unsigned blend);
        int unsigned vals [5];
        vals = '{root, len, st, tight, blend};
        for (int i = 0; i < 5; i++) begin
            cfg_valid <= 1;
            cfg_index <= 3'(i);
            cfg_data <= vals[i];
            do @(posedge aclk); while (!cfg_ready);
        end
        cfg_valid <= 0;
        cur_root = root & 127;
        phases_run++;
    endtask

    function automatic in_item_t mk(kind_t k, int unsigned nt, int unsigned vel,
                                    int unsigned ofs, int unsigned sc);
        in_item_t it;
        it = in_item_t'({$urandom, $urandom, $urandom, $urandom});
        it.kind = k;
        it.note = 7'(nt);
        it.velocity = 7'(vel);
        it.timing_offset = 17'(ofs);
        it.sidechain_pitch = 19'(sc);
        return it;
    endfunction

    function automatic in_item_t mk_write(int unsigned a, int unsigned l, int unsigned r);
        in_item_t it;
        it = mk(KIND_WRITE, $urandom, $urandom, $urandom, $urandom);
        it.sample_address = 16'(a);
        it.sample_left = 16'(l);
        it.sample_right = 16'(r);
        return it;
    endfunction

    function automatic in_item_t rand_item();
        int unsigned pick, nt, ofs;
        int d;
        pick = $urandom_range(99);
        d = int'(cur_root) + int'($urandom_range(48)) - 24;
        nt = ($urandom_range(1) == 0) ? $urandom_range(127) : ((d < 0) ? 0 : (d > 127) ? 127 : d);
        ofs = ($urandom_range(3) == 0) ? $urandom_range(131071) : $urandom_range(4096);
        if (pick < 15)
            return mk(KIND_NOTE_ON, nt, ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 127),
                      ofs, $urandom);
        if (pick < 20)
            return mk(KIND_NOTE_OFF, $urandom, $urandom, $urandom, $urandom);
        if (pick < 25)
            return mk_write(($urandom_range(3) == 0) ? $urandom_range(65535)
                                                     : $urandom_range(FILLED - 1),
                            $urandom, $urandom);
        return mk(KIND_TICK, $urandom, $urandom, ofs, $urandom_range(524287));
    endfunction

    initial begin
        int unsigned roots [8]  = '{60, 0, 127, 69, 45, 72, 100, 60};
        int unsigned lens [8]   = '{16, 1, 2, 0, 300, 65536, 131071, 40};
        int unsigned tights [8] = '{0, 65536, 131071, 0, 20000, 65536, 0, 131071};
        int unsigned blends [8] = '{0, 0, 65536, 131071, 30000, 65536, 0, 131071};
        aresetn = 0;
        s_valid = 0;
        s_item = '0;
        cfg_valid = 0;
        cfg_index = '0;
        cfg_data = '0;
        calm = 0;
        hold_req = 0;
        since_rewind = 0;
        items_sent = 0;
        phases_run = 0;
        cur_root = 60;
        repeat (6) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // fill the frames every tick may read, extremes first
        send(mk_write(0, 16'h7FFF, 16'h8000));
        send(mk_write(1, 16'h8000, 16'h7FFF));
        for (int a = 2; a < FILLED; a++) send(mk_write(a, $urandom, $urandom));
        send(mk_write(65535, 16'hFFFF, 16'h0000));
        since_rewind = 0;
        drain();
        set_regs(60, 16, 1, 0, 0);

        // directed part
        send(mk(KIND_TICK, 0, 0, 0, 0));
        send(mk(KIND_NOTE_ON, 60, 127, 0, 0));
        send(mk(KIND_TICK, 0, 0, 0, 0));
        send(mk(KIND_TICK, 0, 0, 65536, 0));
        send(mk(KIND_TICK, 0, 0, 131071, 524287));
        send(mk(KIND_NOTE_ON, 127, 1, 0, 0));
        send(mk(KIND_TICK, 0, 0, 0, 320));
        send(mk(KIND_TICK, 0, 0, 0, 321));
        send(mk(KIND_NOTE_ON, 0, 0, 0, 0));
        send(mk(KIND_TICK, 0, 0, 0, 0));
        send(mk(KIND_NOTE_ON, 0, 127, 0, 0));
        send(mk(KIND_TICK, 0, 0, 0, 0));
        send(mk(KIND_NOTE_OFF, 0, 0, 0, 0));
        send(mk(KIND_TICK, 0, 0, 0, 0));
        send(mk(KIND_NOTE_ON, 84, 127, 0, 0));
        for (int i = 0; i < 8; i++) send(mk(KIND_TICK, 0, 0, 65536, 0));
        send(mk_write(3, 16'h1234, 16'hEDCB));
        send(mk(KIND_TICK, 0, 0, 0, 0));

        for (int ph = 0; ph < 9; ph++) begin
            drain();
            if (ph < 8)
                set_regs(roots[ph], lens[ph], ph % 2, tights[ph], blends[ph]);
            else
                set_regs($urandom_range(127), $urandom_range(1, FILLED), $urandom_range(1),
                         $urandom_range(131071), $urandom_range(131071));
            calm = (ph == 4);
            for (int i = 0; i < 47; i++) begin
                if (ph == 2 && i == 10) hold_req = 1;
                send(rand_item());
            end
            calm = 0;
        end

        drain();
        $display("ran %0d input items over %0d register settings, %0d tick results checked",
                 items_sent, phases_run, ticks_checked);
        $display("stalls, a long output hold-off and drained pauses were exercised");
        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
